@@ hdl/fsfe_pkg.sv @@
// Package for the four-sample frequency estimator: widths, CORDIC table, states.
// No dependencies.
`default_nettype none
package fsfe_pkg;
	localparam int SampleW   = 16;
	localparam int RateW     = 16;
	localparam int LenW      = 13;
	localparam int MeanW     = 23;
	localparam int SumW      = 35;
	localparam int IdxW      = 12;
	localparam int FracBits  = 16;
	localparam int MaxBlock  = 4096;
	localparam int CordSteps = 16;
	localparam int TurnBits  = 20;
	// CORDIC datapath width: |X|,|Y| up to about 2^17 * 1.65
	localparam int CW        = 21;
	localparam int ZW        = 22;
	// Divider width: dividend |num| << 16 fits in 33 bits
	localparam int DivW      = 33;

	localparam logic [0:0] RegSampleRate  = 1'b0;
	localparam logic [0:0] RegBlockLength = 1'b1;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_DIV   = 8'b0000_0010,
		ST_SQRT  = 8'b0000_0100,
		ST_CORD  = 8'b0000_1000,
		ST_MUL   = 8'b0001_0000,
		ST_ACC   = 8'b0010_0000,
		ST_MEAN  = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	function automatic logic [ZW-1:0] atan_turn(input logic [3:0] i);
		case (i)
			4'd0:  atan_turn = ZW'(131072);
			4'd1:  atan_turn = ZW'(77376);
			4'd2:  atan_turn = ZW'(40884);
			4'd3:  atan_turn = ZW'(20753);
			4'd4:  atan_turn = ZW'(10417);
			4'd5:  atan_turn = ZW'(5213);
			4'd6:  atan_turn = ZW'(2607);
			4'd7:  atan_turn = ZW'(1304);
			4'd8:  atan_turn = ZW'(652);
			4'd9:  atan_turn = ZW'(326);
			4'd10: atan_turn = ZW'(163);
			4'd11: atan_turn = ZW'(81);
			4'd12: atan_turn = ZW'(41);
			4'd13: atan_turn = ZW'(20);
			4'd14: atan_turn = ZW'(10);
			4'd15: atan_turn = ZW'(5);
			default: atan_turn = '0;
		endcase
	endfunction
endpackage
`default_nettype wire

@@ hdl/fsfe_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on fsfe_pkg.
`default_nettype none
module fsfe_divider (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [fsfe_pkg::DivW+2-1:0]   dividend,
	input  wire logic [fsfe_pkg::DivW+2-1:0]   divisor,
	output logic                               done,
	output logic [fsfe_pkg::DivW+2-1:0]        quotient
);
	import fsfe_pkg::*;
	localparam int W = DivW + 2;
	localparam int CntW = $clog2(W + 1);

	logic [W-1:0]    rem_q, quo_q, dvs_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic [W:0]      trial;

	assign trial = {rem_q[W-1:0], quo_q[W-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule
`default_nettype wire

@@ hdl/fsfe_core.sv @@
// Sequencer and shared datapath for one window: ratio divide, isqrt, CORDIC,
// scaling, accumulation and block mean. Depends on fsfe_pkg, fsfe_divider.
`default_nettype none
module fsfe_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic signed [fsfe_pkg::SampleW-1:0] in_sample,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [fsfe_pkg::MeanW-1:0]          out_mean,
	input  wire logic [fsfe_pkg::RateW-1:0]     sample_rate,
	input  wire logic [fsfe_pkg::LenW-1:0]      block_length
);
	import fsfe_pkg::*;
	localparam int DW = DivW + 2;

	state_t state_q;
	logic signed [SampleW-1:0] h0_q, h1_q, h2_q, s_q;
	logic [IdxW-1:0]  idx_q;
	logic [SumW-1:0]  sum_q;
	logic [MeanW-1:0] mean_q;
	logic             last_q, neg_q, oor_q;
	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [4:0]           step_q;
	// isqrt registers
	logic [35:0]          sv_q;
	logic [35:0]          sr_q;
	logic [35:0]          sb_q;
	logic [RateW+TurnBits-1:0] prod_q;
	logic [LenW-1:0]      len;

	// divider
	logic          div_start;
	logic [DW-1:0] div_a, div_b, div_q;
	logic          div_done;
	logic          div_ratio_q;

	fsfe_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_b), .done(div_done), .quotient(div_q)
	);

	always_comb begin
		if (block_length < LenW'(4))
			len = LenW'(4);
		else if (block_length > LenW'(MaxBlock))
			len = LenW'(MaxBlock);
		else
			len = block_length;
	end

	logic signed [SampleW:0] num, den;
	logic [SampleW:0] an, ad;
	assign num = {s_q[SampleW-1], s_q} - {h0_q[SampleW-1], h0_q};
	assign den = {h2_q[SampleW-1], h2_q} - {h1_q[SampleW-1], h1_q};
	assign an  = num[SampleW] ? (SampleW+1)'(0) - num : num;
	assign ad  = den[SampleW] ? (SampleW+1)'(0) - den : den;

	// ratio saturation and x
	localparam logic [DW-1:0] RMax = DW'((64'd1 << (FracBits + 7)) - 1);
	localparam logic [DW-1:0] RNegMax = DW'(64'd1 << (FracBits + 7));
	logic signed [DW:0] ratio, xw;
	always_comb begin
		if (neg_q)
			ratio = (div_q > RNegMax) ? -$signed({1'b0, RNegMax})
			                          : -$signed({1'b0, div_q});
		else
			ratio = (div_q > RMax) ? $signed({1'b0, RMax}) : $signed({1'b0, div_q});
		xw = ratio - (DW+1)'(1 << FracBits);
	end

	localparam logic signed [DW:0] TwoOne = (DW+1)'(2 << FracBits);

	// x fits CW bits inside the acos domain; outside it, x and its square go unused
	logic signed [CW-1:0]   xc;
	logic signed [2*CW-1:0] xsq;
	assign xc  = CW'(xw);
	assign xsq = xc * xc;

	logic seq_start;
	assign seq_start = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);

	// isqrt step
	logic [35:0] s_sum;
	assign s_sum = sr_q + sb_q;

	// CORDIC step
	logic signed [CW-1:0] dx, dy;
	assign dx = y_q >>> step_q[3:0];
	assign dy = x_q >>> step_q[3:0];

	logic [SumW:0]   sum_n;
	logic [SumW-1:0] sum_sat;
	assign sum_n   = {1'b0, sum_q} + (SumW+1)'(prod_q >> (TurnBits - 8));
	assign sum_sat = sum_n[SumW] ? {SumW{1'b1}} : sum_n[SumW-1:0];

	// start of divider: ratio or mean
	always_comb begin
		div_start = 1'b0;
		div_a = '0;
		div_b = '0;
		if (state_q == ST_ACC && last_q) begin
			div_start = 1'b1;
			div_a = DW'(sum_sat);
			div_b = DW'(len - LenW'(3));
		end else if (div_ratio_q) begin
			div_start = 1'b1;
			div_a = DW'({an, {FracBits{1'b0}}});
			div_b = DW'(ad);
		end
	end

	// output word register: load the block mean once the previous word has left
	logic [MeanW-1:0] mean_sat;
	logic             out_load;
	assign mean_sat = (div_q > DW'({MeanW{1'b1}})) ? {MeanW{1'b1}} : div_q[MeanW-1:0];
	assign out_load = (state_q == ST_OUT) && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load)
			mean_q <= mean_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			h0_q <= '0; h1_q <= '0; h2_q <= '0;
			idx_q       <= '0;
			sum_q       <= '0;
			div_ratio_q <= 1'b0;
		end else begin
			div_ratio_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (seq_start) begin
						s_q    <= in_sample;
						last_q <= ({1'b0, idx_q} + (IdxW+1)'(1)) >= (IdxW+1)'(len);
						if (idx_q >= IdxW'(3)) begin
							state_q     <= ST_DIV;
							div_ratio_q <= 1'b1;
						end else begin
							prod_q  <= '0;
							state_q <= ST_ACC;
						end
					end
				end
				ST_DIV: begin
					neg_q <= num[SampleW] ^ den[SampleW];
					if (den == '0) begin
						x_q   <= '0;
						oor_q <= 1'b0;
						sv_q  <= 36'd1 << (2 * FracBits + 2);
						sr_q  <= '0;
						sb_q  <= 36'd1 << 34;
						state_q <= ST_SQRT;
					end else if (div_done) begin
						oor_q <= (xw > TwoOne) || (xw < -TwoOne);
						x_q   <= xc;
						sv_q  <= (36'd1 << (2 * FracBits + 2)) - 36'(xsq);
						sr_q  <= '0;
						sb_q  <= 36'd1 << 34;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (oor_q) begin
						prod_q  <= '0;
						state_q <= ST_ACC;
					end else if (sb_q != '0) begin
						if (sv_q >= s_sum) begin
							sv_q <= sv_q - s_sum;
							sr_q <= (sr_q >> 1) + sb_q;
						end else begin
							sr_q <= sr_q >> 1;
						end
						sb_q <= sb_q >> 2;
					end else begin
						step_q <= '0;
						if (x_q < 0) begin
							y_q <= -x_q;
							x_q <= CW'(sr_q);
							z_q <= ZW'(1 << (TurnBits - 2));
						end else begin
							y_q <= CW'(sr_q);
							z_q <= '0;
						end
						state_q <= ST_CORD;
					end
				end
				ST_CORD: begin
					if (step_q == 5'(CordSteps)) begin
						state_q <= ST_MUL;
						if (z_q < 0)
							z_q <= '0;
						else if (z_q > ZW'(1 << (TurnBits - 1)))
							z_q <= ZW'(1 << (TurnBits - 1));
					end else begin
						if (y_q > 0) begin
							x_q <= x_q + dx;
							y_q <= y_q - dy;
							z_q <= z_q + atan_turn(step_q[3:0]);
						end else begin
							x_q <= x_q - dx;
							y_q <= y_q + dy;
							z_q <= z_q - atan_turn(step_q[3:0]);
						end
						step_q <= step_q + 1'b1;
					end
				end
				ST_MUL: begin
					prod_q  <= sample_rate * z_q[TurnBits-1:0];
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					h0_q <= h1_q; h1_q <= h2_q; h2_q <= s_q;
					if (idx_q >= IdxW'(3))
						sum_q <= sum_sat;
					if (last_q) begin
						idx_q   <= '0;
						state_q <= ST_MEAN;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_MEAN: begin
					if (div_done) begin
						sum_q   <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold the quotient until the output register is free
					if (!out_valid || out_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_mean = mean_q;
endmodule
`default_nettype wire

@@ hdl/four_sample_freq_estimator_unit.sv @@
// Top level: configuration registers and the stream ports around fsfe_core.
// Depends on fsfe_pkg, fsfe_core.
//
//  channel  | direction | word
//  s_axis   | in        | tdata[15:0] sample
//  m_axis   | out       | tdata[22:0] mean_freq, zero-filled to 24 bits
//  cfg      | in        | index 0 sample_rate, 1 block_length
//
// A window sample is accepted, then passes the divide state (serial divider plus start
// and done), the isqrt loop, the CORDIC steps, one multiply and one accumulate. A ratio
// outside the acos domain skips isqrt, CORDIC and multiply; equal middle samples skip only
// the wait for the divider. The first three samples of a block go straight to accumulate.
// The last sample adds the mean divide and the load of the output word.
// Reset is asynchronous; s_axis_tready is low while a sample is in work and while a new
// mean waits for the previous word to leave.
`default_nettype none
module four_sample_freq_estimator_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // [22:0] mean_freq
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import fsfe_pkg::*;

	logic [RateW-1:0] rate_q;
	logic [LenW-1:0]  len_q;
	logic [MeanW-1:0] mean;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RateW'(16000);
			len_q  <= LenW'(3072);
		end else if (cfg_valid) begin
			case (cfg_index)
				RegSampleRate:  rate_q <= cfg_data;
				RegBlockLength: len_q  <= cfg_data[LenW-1:0];
				default: ;
			endcase
		end
	end

	fsfe_core u_core (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_sample($signed(s_axis_tdata)),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_mean(mean),
		.sample_rate(rate_q), .block_length(len_q)
	);

	assign m_axis_tdata = {1'b0, mean};
endmodule
`default_nettype wire
